// ===== design/te_pkg.sv =====
// ----------------------------------------------------------------------------
// te_pkg
// Shared types and constants for the tricorn escape-time evaluator.
// ----------------------------------------------------------------------------
package te_pkg;

    // field widths
    localparam int COORD_BITS = 12;
    localparam int CNT_BITS   = 16;
    localparam int DATA_BITS  = 32;
    localparam int IDX_BITS   = 3;

    // configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_SCALE_X  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_SCALE_Y  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_OFFSET_X = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_OFFSET_Y = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_MAX_ITER = 3'd4;

    // default iteration limit
    localparam logic [CNT_BITS-1:0] MAX_ITER_RESET = 16'd256;

    // input beat
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_pix_in;

    // output beat
    typedef struct packed {
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic [CNT_BITS-1:0]   escape_count;
    } t_pix_out;

    // controller to datapath
    typedef struct packed {
        logic load_pixel;
        logic map_mul;
        logic map_add;
        logic iter_mul;
        logic iter_upd;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic below_max;
        logic escaped;
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/te_datapath.sv =====
// ----------------------------------------------------------------------------
// te_datapath
// Configuration registers, pixel mapping, shared iteration multipliers,
// iteration counter and output register.
// ----------------------------------------------------------------------------
module te_datapath #(
    parameter int FRAC_BITS = 26
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [te_pkg::IDX_BITS-1:0]  i_cfg_index,
    input  logic [te_pkg::DATA_BITS-1:0] i_cfg_data,
    input  te_pkg::t_pix_in              i_in_data,
    input  logic                         i_out_stall,
    input  te_pkg::t_dp_cmd              i_cmd,
    output te_pkg::t_dp_status           o_status,
    output logic                         o_out_valid,
    output te_pkg::t_pix_out             o_out_data
);
    import te_pkg::*;

    localparam logic [DATA_BITS-1:0] ESC_LIMIT = DATA_BITS'(64'd1 << (FRAC_BITS + 2));

    logic [DATA_BITS-1:0]  r_scale_x, r_scale_y, r_offset_x, r_offset_y;
    logic [CNT_BITS-1:0]   r_max_iter;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [DATA_BITS-1:0]  r_mx, r_my;
    logic [DATA_BITS-1:0]  r_cx, r_cy, r_x, r_y;
    logic [DATA_BITS-1:0]  r_sx, r_sy, r_t;
    logic [CNT_BITS-1:0]   r_n;
    logic                  r_out_valid;
    t_pix_out              r_out_data;

    logic [DATA_BITS-1:0]  w_mx, w_my;
    logic signed [63:0]    w_xx, w_yy, w_xy;
    logic [DATA_BITS-1:0]  w_mag;
    logic                  w_take;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x  <= '0;
            r_scale_y  <= '0;
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_max_iter <= MAX_ITER_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SCALE_X:  r_scale_x  <= i_cfg_data;
                REG_SCALE_Y:  r_scale_y  <= i_cfg_data;
                REG_OFFSET_X: r_offset_x <= i_cfg_data;
                REG_OFFSET_Y: r_offset_y <= i_cfg_data;
                REG_MAX_ITER: r_max_iter <= i_cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pixel to complex point, products wrap to 32 bits
    assign w_mx = {{(DATA_BITS-COORD_BITS){1'b0}}, r_px} * r_scale_x;
    assign w_my = {{(DATA_BITS-COORD_BITS){1'b0}}, r_py} * r_scale_y;

    // iteration multipliers
    assign w_xx = 64'($signed(r_x)) * 64'($signed(r_x));
    assign w_yy = 64'($signed(r_y)) * 64'($signed(r_y));
    assign w_xy = 64'($signed(r_x)) * 64'($signed(r_y));

    // squared magnitude, wrapped
    assign w_mag = r_sx + r_sy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pixel) begin
            r_px <= i_in_data.pixel_x;
            r_py <= i_in_data.pixel_y;
        end
        if (i_cmd.map_mul) begin
            r_mx <= w_mx;
            r_my <= w_my;
        end
        if (i_cmd.map_add) begin
            r_cx <= r_mx + r_offset_x;
            r_cy <= r_my + r_offset_y;
            r_x  <= r_mx + r_offset_x;
            r_y  <= r_my + r_offset_y;
            r_n  <= '0;
        end
        if (i_cmd.iter_mul) begin
            r_sx <= w_xx[FRAC_BITS+DATA_BITS-1:FRAC_BITS];
            r_sy <= w_yy[FRAC_BITS+DATA_BITS-1:FRAC_BITS];
            r_t  <= w_xy[FRAC_BITS+DATA_BITS-2:FRAC_BITS-1];
        end
        if (i_cmd.iter_upd) begin
            r_x <= r_sx - r_sy + r_cx;
            r_y <= r_cy - r_t;
            r_n <= r_n + 1'b1;
        end
    end

    // output register, freed when the beat is taken
    assign w_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.out_x        <= r_px;
            r_out_data.out_y        <= r_py;
            r_out_data.escape_count <= (r_n < r_max_iter) ? r_n : '0;
        end
    end

    // status to the controller
    assign o_status.below_max = (r_n < r_max_iter);
    assign o_status.escaped   = ($signed(w_mag) >= $signed(ESC_LIMIT));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== design/te_ctrl.sv =====
// ----------------------------------------------------------------------------
// te_ctrl
// Sequencer for mapping, the iteration loop (multiply, then update) and result hand-off.
// ----------------------------------------------------------------------------
module te_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  te_pkg::t_dp_status i_status,
    output logic               o_in_stall,
    output te_pkg::t_dp_cmd    o_cmd
);
    import te_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MAP_MUL  = 3'd1;
    localparam logic [2:0] S_MAP_ADD  = 3'd2;
    localparam logic [2:0] S_ITER_MUL = 3'd3;
    localparam logic [2:0] S_ITER_UPD = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_pixel = 1'b1;
                    n_state          = S_MAP_MUL;
                end
            end
            S_MAP_MUL: begin
                o_cmd.map_mul = 1'b1;
                n_state       = S_MAP_ADD;
            end
            S_MAP_ADD: begin
                o_cmd.map_add = 1'b1;
                n_state       = S_ITER_MUL;
            end
            S_ITER_MUL: begin
                if (i_status.below_max) begin
                    o_cmd.iter_mul = 1'b1;
                    n_state        = S_ITER_UPD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_ITER_UPD: begin
                if (i_status.escaped) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.iter_upd = 1'b1;
                    n_state        = S_ITER_MUL;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== design/tricorn_escape_time.sv =====
// ----------------------------------------------------------------------------
// tricorn_escape_time
// Escape-time evaluator for the tricorn set in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : one beat per pixel (pixel_x, pixel_y), valid/stall
//   output channel : one beat per pixel (out_x, out_y, escape_count)
//   config channel : valid/ready write of scale_x, scale_y, offset_x,
//                    offset_y (index 0..3) and max_iter (index 4); ready is
//                    always high, writes to other indexes are dropped;
//                    write only while the block is idle
// Sequence: after input accept, a map multiply step and a map add step, then
//   the iteration loop until the pixel escapes or runs out the limit, then
//   the output load. Each iteration registers the products of the three shared
//   32x32 multipliers, then checks the magnitude and updates in the adders.
// Throughput: one pixel at a time; a new pixel is accepted the cycle after
//   the previous result is loaded into the output register.
// Reset: configuration returns to zero scale/offset and max_iter 256, the
//   sequencer goes idle and the output register empties.
// Receiver stall: the finished result holds in the output register; the
//   next pixel still gets accepted and computed, and waits only at hand-off.
// ----------------------------------------------------------------------------
module tricorn_escape_time #(
    parameter int FRAC_BITS = 26
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  te_pkg::t_pix_in              i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output te_pkg::t_pix_out             o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [te_pkg::IDX_BITS-1:0]  i_cfg_index,
    input  logic [te_pkg::DATA_BITS-1:0] i_cfg_data
);
    import te_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    te_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // arithmetic and registers
    te_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/te_checker.sv =====
// ----------------------------------------------------------------------------
// te_checker
// Port-level checks for the tricorn escape-time evaluator, bound to the top.
// ----------------------------------------------------------------------------
module te_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input te_pkg::t_pix_out   o_out_data
);
    import te_pkg::*;

    logic w_in_take;

    assign w_in_take = i_in_valid && !o_in_stall;

    // output register empties on reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    // one pixel in flight: busy right after accepting
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> o_in_stall)
        else $error("second pixel accepted while busy");

    // mapping takes cycles, so no result appears right after accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> !$rose(o_out_valid))
        else $error("result appeared right after accept");

endmodule

bind tricorn_escape_time te_checker u_te_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== verif/tricorn_escape_time_tb.sv =====
// ----------------------------------------------------------------------------
// tricorn_escape_time_tb
// Self-checking bench for the tricorn escape-time evaluator. Drives pixel
// beats under several scale/offset/limit settings, predicts each escape
// count in fixed point and checks every output beat in order.
// ----------------------------------------------------------------------------
module tricorn_escape_time_tb;
    import te_pkg::*;

    localparam int FRAC        = 26;
    localparam logic [COORD_BITS-1:0] MAX_COORD = '1;
    // longest quiet spell: a never-escaping pixel at the top limit plus stalls
    localparam int STALL_LIMIT = 600000;
    localparam logic signed [DATA_BITS-1:0] RADIUS_SQ = 32'sh1000_0000;

    // ------------------------------------------------------------------------
    // escape-count predictor and expected-beat store
    // ------------------------------------------------------------------------
    class escape_scoreboard;
        logic [DATA_BITS-1:0] scale_x, scale_y, offset_x, offset_y;
        logic [CNT_BITS-1:0]  max_iter;
        t_pix_out             expected_q[$];
        int                   mismatches;

        function new();
            scale_x    = '0;
            scale_y    = '0;
            offset_x   = '0;
            offset_y   = '0;
            max_iter   = MAX_ITER_RESET;
            mismatches = 0;
        endfunction

        function void apply_reg(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
            case (idx)
                REG_SCALE_X:  scale_x  = val;
                REG_SCALE_Y:  scale_y  = val;
                REG_OFFSET_X: offset_x = val;
                REG_OFFSET_Y: offset_y = val;
                REG_MAX_ITER: max_iter = val[CNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // signed product, optionally doubled, floor-shifted and wrapped
        function logic [DATA_BITS-1:0] fx_mul(logic [DATA_BITS-1:0] a,
                                              logic [DATA_BITS-1:0] b, bit dbl);
            logic [63:0] prod;
            prod = longint'($signed(a)) * longint'($signed(b));
            if (dbl)
                prod = prod << 1;
            return prod[FRAC +: DATA_BITS];
        endfunction

        function logic [CNT_BITS-1:0] escape_count(logic [COORD_BITS-1:0] px,
                                                   logic [COORD_BITS-1:0] py);
            logic [DATA_BITS-1:0] cx, cy, x, y, sx, sy, t;
            int                   n;
            bit                   escaped;
            cx      = {{(DATA_BITS-COORD_BITS){1'b0}}, px} * scale_x + offset_x;
            cy      = {{(DATA_BITS-COORD_BITS){1'b0}}, py} * scale_y + offset_y;
            x       = cx;
            y       = cy;
            n       = 0;
            escaped = 1'b0;
            while (!escaped && n < int'(max_iter)) begin
                sx = fx_mul(x, x, 1'b0);
                sy = fx_mul(y, y, 1'b0);
                // a wrapped magnitude that reads negative stays inside
                if ($signed(sx + sy) >= RADIUS_SQ) begin
                    escaped = 1'b1;
                end else begin
                    t = fx_mul(x, y, 1'b1);
                    x = sx - sy + cx;
                    y = cy - t;
                    n++;
                end
            end
            if (n >= int'(max_iter))
                n = 0;
            return n[CNT_BITS-1:0];
        endfunction

        function void note_pixel(t_pix_in beat);
            t_pix_out exp_beat;
            exp_beat.out_x        = beat.pixel_x;
            exp_beat.out_y        = beat.pixel_y;
            exp_beat.escape_count = escape_count(beat.pixel_x, beat.pixel_y);
            expected_q.push_back(exp_beat);
        endfunction

        function void check_result(t_pix_out beat);
            t_pix_out exp_beat;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat x=%0d y=%0d count=%0d",
                             beat.out_x, beat.out_y, beat.escape_count);
                return;
            end
            exp_beat = expected_q.pop_front();
            if (beat.out_x !== exp_beat.out_x || beat.out_y !== exp_beat.out_y ||
                beat.escape_count !== exp_beat.escape_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected x=%0d y=%0d count=%0d, ",
                              "got x=%0d y=%0d count=%0d"},
                             exp_beat.out_x, exp_beat.out_y, exp_beat.escape_count,
                             beat.out_x, beat.out_y, beat.escape_count);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic                  i_clk     = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_pix_in               in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [IDX_BITS-1:0]   cfg_index = '0;
    logic [DATA_BITS-1:0]  cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_pix_out              o_out_data;
    logic                  o_cfg_ready;

    bit                    no_idle = 1'b0;
    int                    quiet_cycles = 0;
    escape_scoreboard      sb = new();

    always #5 i_clk = ~i_clk;

    tricorn_escape_time #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // result side: random stall, beat check and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (o_out_valid && !out_stall)
                sb.check_result(o_out_data);
            out_stall <= !no_idle && ($urandom_range(99) < 35);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------------
    // one pixel beat; valid stays high into the next call unless it idles
    task automatic send_pixel(input logic [COORD_BITS-1:0] x,
                              input logic [COORD_BITS-1:0] y);
        t_pix_in beat;
        if (!no_idle && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        beat.pixel_x = x;
        beat.pixel_y = y;
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(beat);
    endtask

    task automatic send_random(input int count, input int x_lo, input int x_hi);
        repeat (count)
            send_pixel(COORD_BITS'($urandom_range(x_hi, x_lo)),
                       COORD_BITS'($urandom_range(MAX_COORD, 0)));
    endtask

    // drop valid and wait for every expected beat
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx,
                             input logic [DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.apply_reg(idx, val);
    endtask

    // full register set plus a write to an unused index, which must be dropped
    task automatic configure(input logic [DATA_BITS-1:0] sx, input logic [DATA_BITS-1:0] sy,
                             input logic [DATA_BITS-1:0] ox, input logic [DATA_BITS-1:0] oy,
                             input logic [CNT_BITS-1:0] limit);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        // upper bits are outside the limit field
        write_reg(REG_MAX_ITER, {16'($urandom), limit});
        write_reg(REG_MAX_ITER + IDX_BITS'($urandom_range(3, 1)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: every pixel maps to the origin and never escapes
        send_pixel('0, '0);
        send_pixel(MAX_COORD, MAX_COORD);
        send_pixel(MAX_COORD, '0);
        send_pixel('0, MAX_COORD);
        drain();

        // full view: 3.5 wide, 2 high, from (-2.5, -1)
        configure(32'd57344, 32'd32768, -32'sd167772160, -32'sd67108864, 16'd256);
        send_pixel('0, '0);
        send_pixel(MAX_COORD, MAX_COORD);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd2926, 12'd2048);
        no_idle = 1'b1;
        send_random(90, 0, MAX_COORD);
        no_idle = 1'b0;
        send_random(90, 0, MAX_COORD);
        drain();

        // zoomed view near the boundary with a deeper limit
        configure(32'd4096, 32'd4096, -32'sd67108864, -32'sd8388608, 16'd1000);
        send_random(60, 0, MAX_COORD);
        drain();

        // extreme registers: products and sums wrap, one iteration at most
        configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
        send_pixel('0, '0);
        send_pixel(MAX_COORD, MAX_COORD);
        send_random(10, 0, MAX_COORD);
        drain();

        // limit of zero: no iteration, count zero
        configure($urandom, $urandom, $urandom, $urandom, 16'd0);
        send_random(10, 0, MAX_COORD);
        drain();

        // random raw settings with short limits
        repeat (4) begin
            configure($urandom, $urandom, $urandom, $urandom,
                      CNT_BITS'($urandom_range(48, 2)));
            send_random(25, 0, MAX_COORD);
            drain();
        end

        // top limit: origin runs out the limit, far-right columns escape at once
        configure(32'd57344, 32'd57344, 32'd0, 32'd0, 16'hFFFF);
        send_pixel('0, '0);
        send_pixel(MAX_COORD, MAX_COORD);
        send_random(20, 2400, MAX_COORD);
        drain();

        // settle, then verdict
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/te_pkg.sv
design/te_datapath.sv
design/te_ctrl.sv
design/tricorn_escape_time.sv
design/te_checker.sv
verif/tricorn_escape_time_tb.sv
